### src/rlcd_pkg.sv
package rlcd_pkg;

    localparam int SYM_W     = 8;
    localparam int LEN_W     = 10;
    localparam int CFG_W     = 1;
    localparam int BCD_DIGS  = 4;
    localparam int MAX_RES   = 6;
    localparam int CNT_W     = 3;
    localparam int PROD_W    = 14;
    localparam int M_TDATA_W = 24;
    localparam int MAX_RUN_DEFAULT = 1023;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [3:0]       t_bcd;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CFG_W-1:0] {
        MODE_COMPRESS   = 1'b0,
        MODE_DECOMPRESS = 1'b1
    } t_mode;

    localparam t_sym ASCII_ZERO = 8'h30;
    localparam t_sym ASCII_NINE = 8'h39;
    localparam t_bcd BCD_NINE   = 4'd9;

    // Decimal increment of a four-digit packed count, ones digit in slot 0.
    function automatic logic [4*BCD_DIGS-1:0] bcd_inc(input logic [4*BCD_DIGS-1:0] v);
        logic [4*BCD_DIGS-1:0] r;
        logic                  carry;
        r     = v;
        carry = 1'b1;
        for (int k = 0; k < BCD_DIGS; k++) begin
            if (carry) begin
                if (v[4*k +: 4] == BCD_NINE) begin
                    r[4*k +: 4] = 4'd0;
                end else begin
                    r[4*k +: 4] = v[4*k +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

### src/run_length_codec_decimal_unit.sv
// Channel   Direction  Beat contents
// s (in)    slave      tdata: symbol[7:0]; tlast: is_last
// m (out)   master     tdata: out_symbol[7:0], repeat_res[17:8], zero[23:18];
//                      tlast: end_of_stream
// cfg       write      data: mode[0]
//
// One input beat is taken per cycle while input is ready; its results (up to six)
// are formed in that same cycle into a result shift register, which drains one
// beat per cycle while the output is ready. Input is ready while that register
// is empty or on the cycle its last beat leaves. Reset is synchronous, active
// low, and clears mode, the open run and the gathered decimal count. A stalled
// output holds the input side.
module run_length_codec_decimal_unit #(
    parameter int MAX_RUN = rlcd_pkg::MAX_RUN_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rlcd_pkg::CFG_W-1:0]       i_cfg_data,   // mode
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rlcd_pkg::SYM_W-1:0]       i_s_tdata,    // symbol
    input  logic                             i_s_tlast,    // is_last
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [rlcd_pkg::M_TDATA_W-1:0]   o_m_tdata,    // out_symbol, repeat_res, pad
    output logic                             o_m_tlast     // end_of_stream
);
    import rlcd_pkg::*;

    localparam t_len MaxRunW = LEN_W'(MAX_RUN);
    localparam logic [4*BCD_DIGS-1:0] BcdOne = (4*BCD_DIGS)'(1);

    // State
    t_mode                 r_mode;
    t_sym                  r_held;
    t_len                  r_run_len;
    logic [4*BCD_DIGS-1:0] r_run_bcd;
    t_len                  r_dig_cnt;

    // Result shift register
    t_sym                  r_slot [MAX_RES];
    t_cnt                  r_cnt;
    t_len                  r_rep;
    logic                  r_eos;

    logic                  s_acc;
    logic                  m_acc;

    // Compress path
    logic                  c_open, c_break, c_close_cur, c_emit, c_tail;
    t_len                  c_len1, c_em_len, c_n_len;
    logic [4*BCD_DIGS-1:0] c_bcd1, c_em_bcd, c_n_bcd;
    t_sym                  c_em_byte;
    t_cnt                  c_nd, c_cnt;
    t_sym                  c_slot [MAX_RES];

    // Decompress path
    logic                  d_is_dig;
    logic [PROD_W-1:0]     d_next;
    t_len                  d_sat, d_n_cnt, d_rep;

    t_cnt                  n_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && i_m_tready);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_acc       = o_m_tvalid && i_m_tready;

    assign o_m_tvalid  = (r_cnt != '0);
    assign o_m_tdata   = {(M_TDATA_W - SYM_W - LEN_W)'(0), r_rep, r_slot[0]};
    assign o_m_tlast   = r_eos && (r_cnt == t_cnt'(1));

    // Compression: the run that leaves is the old one (byte changed, plus the new
    // byte on the last flag) or the current one closed by the limit or the last flag.
    always_comb begin
        c_open      = (r_run_len != '0);
        c_break     = c_open && (i_s_tdata != r_held);
        c_len1      = (!c_open || c_break) ? t_len'(1) : r_run_len + t_len'(1);
        c_bcd1      = (!c_open || c_break) ? BcdOne : bcd_inc(r_run_bcd);
        c_close_cur = !c_break && ((c_len1 >= MaxRunW) || i_s_tlast);
        c_emit      = c_break || c_close_cur;
        c_tail      = c_break && i_s_tlast;
        c_em_len    = c_break ? r_run_len : c_len1;
        c_em_bcd    = c_break ? r_run_bcd : c_bcd1;
        c_em_byte   = c_break ? r_held : i_s_tdata;

        if (c_em_len <= t_len'(1)) begin
            c_nd = t_cnt'(0);
        end else if (c_em_bcd[15:12] != '0) begin
            c_nd = t_cnt'(4);
        end else if (c_em_bcd[11:8] != '0) begin
            c_nd = t_cnt'(3);
        end else if (c_em_bcd[7:4] != '0) begin
            c_nd = t_cnt'(2);
        end else begin
            c_nd = t_cnt'(1);
        end

        c_cnt = c_emit ? (c_nd + t_cnt'(1) + t_cnt'(c_tail)) : t_cnt'(0);

        // Digits go out most significant first, then the run byte, then the
        // one-byte run opened by a changed last byte.
        for (int k = 0; k < MAX_RES; k++) begin
            if (t_cnt'(k) < c_nd) begin
                c_slot[k] = ASCII_ZERO
                          + t_sym'(c_em_bcd[4*(2'(c_nd - t_cnt'(k) - t_cnt'(1))) +: 4]);
            end else if (t_cnt'(k) == c_nd) begin
                c_slot[k] = c_em_byte;
            end else begin
                c_slot[k] = i_s_tdata;
            end
        end

        if (c_break) begin
            c_n_len = i_s_tlast ? t_len'(0) : t_len'(1);
            c_n_bcd = i_s_tlast ? '0 : BcdOne;
        end else begin
            c_n_len = c_close_cur ? t_len'(0) : c_len1;
            c_n_bcd = c_close_cur ? '0 : c_bcd1;
        end
    end

    // Decompression: count times ten plus digit, saturated.
    always_comb begin
        d_is_dig = (i_s_tdata >= ASCII_ZERO) && (i_s_tdata <= ASCII_NINE);
        d_next   = {1'b0, r_dig_cnt, 3'b000} + {3'b000, r_dig_cnt, 1'b0}
                 + PROD_W'(i_s_tdata[3:0]);
        d_sat    = (d_next > PROD_W'(MaxRunW)) ? MaxRunW : d_next[LEN_W-1:0];
        d_n_cnt  = (d_is_dig && !i_s_tlast) ? d_sat : t_len'(0);
        d_rep    = (r_dig_cnt == '0) ? t_len'(1) : r_dig_cnt;
    end

    always_comb begin
        if (s_acc) begin
            unique case (r_mode)
                MODE_COMPRESS:   n_cnt = c_cnt;
                MODE_DECOMPRESS: n_cnt = d_is_dig ? t_cnt'(0) : t_cnt'(1);
                default:         n_cnt = t_cnt'(0);
            endcase
        end else if (m_acc) begin
            n_cnt = r_cnt - t_cnt'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_COMPRESS;
            r_held    <= '0;
            r_run_len <= '0;
            r_run_bcd <= '0;
            r_dig_cnt <= '0;
            r_cnt     <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            if (s_acc) begin
                if (r_mode == MODE_COMPRESS) begin
                    r_held    <= i_s_tdata;
                    r_run_len <= c_n_len;
                    r_run_bcd <= c_n_bcd;
                end else begin
                    r_dig_cnt <= d_n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_eos <= i_s_tlast;
            if (r_mode == MODE_COMPRESS) begin
                r_rep <= t_len'(1);
                for (int k = 0; k < MAX_RES; k++) begin
                    r_slot[k] <= c_slot[k];
                end
            end else begin
                r_rep     <= d_rep;
                r_slot[0] <= i_s_tdata;
            end
        end else if (m_acc) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(MAX_RES))
        else $error("result count exceeds six");

    a_run_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_len < MaxRunW)
        else $error("open run reached the limit without closing");

    a_bcd_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PROD_W'(r_run_len) == PROD_W'(r_run_bcd[15:12]) * PROD_W'(1000)
                            + PROD_W'(r_run_bcd[11:8]) * PROD_W'(100)
                            + PROD_W'(r_run_bcd[7:4]) * PROD_W'(10)
                            + PROD_W'(r_run_bcd[3:0]))
        else $error("decimal run count disagrees with binary run length");

    // The last flag only clears the state of the mode that takes the beat.
    a_last_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast && (r_mode == MODE_COMPRESS)) |=> (r_run_len == '0))
        else $error("open run not cleared after last beat");

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast && (r_mode == MODE_DECOMPRESS)) |=> (r_dig_cnt == '0))
        else $error("decimal count not cleared after last beat");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rlcd_pkg::*;

    localparam int RUN_LIMIT = MAX_RUN_DEFAULT;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 22;

    // One output beat as the checker sees it.
    typedef struct packed {
        t_sym sym;
        t_len rep;
        logic eos;
    } beat_t;

    // One row of the directed table. The row's byte is sent reps times; is_last
    // goes only on the final copy. A row marked typed carries its own expectation
    // (zero or one beat) instead of the predicted one.
    typedef struct packed {
        t_mode       m;
        t_sym        sym;
        logic        last;
        logic [10:0] reps;
        logic        typed;
        logic        n_exp;
        t_sym        e_sym;
        t_len        e_rep;
        logic        e_eos;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [SYM_W-1:0]     i_s_tdata;
    logic                 i_s_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;

    // Predictor state, kept apart from the block.
    t_mode codec_mode;
    t_sym  run_sym;
    int    run_len;
    int    dec_count;
    beat_t step_beats [MAX_RES];
    int    step_n;

    beat_t codec_beats_due [$];
    beat_t got_beat;
    beat_t want_beat;
    int    errors;
    int    items_sent;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_asked;
    int    hold_served;
    int    hold_left;

    row_t directed_rows [$] = '{
        // mode          sym    last  reps      typed n    e_sym  e_rep    e_eos
        '{MODE_COMPRESS,   "A",   1'b1, 11'd1,    1'b1, 1'b1, "A",   10'd1,    1'b1},
        '{MODE_COMPRESS,   8'h00, 1'b0, 11'd3,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   8'hFF, 1'b1, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        // A run that reaches the limit closes by itself.
        '{MODE_COMPRESS,   "R",   1'b0, 11'd1023, 1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   "R",   1'b1, 11'd2,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        // Four-digit length, byte, then a flushed single byte: six beats at once.
        '{MODE_COMPRESS,   "Q",   1'b0, 11'd1022, 1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   "S",   1'b1, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   "b",   1'b0, 11'd100,  1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   "c",   1'b1, 11'd10,   1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        // Leave a run of digit bytes open across the mode change.
        '{MODE_COMPRESS,   "5",   1'b0, 11'd2,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "9",   1'b0, 11'd4,    1'b1, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "x",   1'b1, 11'd1,    1'b1, 1'b1, "x",   10'd1023, 1'b1},
        '{MODE_DECOMPRESS, "0",   1'b0, 11'd1,    1'b1, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "z",   1'b0, 11'd1,    1'b1, 1'b1, "z",   10'd1,    1'b0},
        '{MODE_DECOMPRESS, 8'hFF, 1'b0, 11'd1,    1'b1, 1'b1, 8'hFF, 10'd1,    1'b0},
        '{MODE_DECOMPRESS, "1",   1'b0, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "2",   1'b0, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, 8'h00, 1'b1, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        // A trailing digit marked last is dropped with its count.
        '{MODE_DECOMPRESS, "7",   1'b1, 11'd1,    1'b1, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "k",   1'b0, 11'd1,    1'b1, 1'b1, "k",   10'd1,    1'b0},
        '{MODE_DECOMPRESS, "4",   1'b0, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_COMPRESS,   "5",   1'b1, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "m",   1'b0, 11'd1,    1'b0, 1'b0, 8'h00, 10'd0,    1'b0},
        '{MODE_DECOMPRESS, "/",   1'b0, 11'd1,    1'b1, 1'b1, "/",   10'd1,    1'b0},
        '{MODE_DECOMPRESS, ":",   1'b1, 11'd1,    1'b1, 1'b1, ":",   10'd1,    1'b1}
    };

    run_length_codec_decimal_unit #(
        .MAX_RUN(RUN_LIMIT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void add_beat(input t_sym s, input t_len r);
        step_beats[step_n] = '{sym: s, rep: r, eos: 1'b0};
        step_n++;
    endfunction

    // Close the open run: decimal length without leading zeros when above one,
    // then the byte itself.
    function automatic void close_run();
        int  scale;
        int  dig;
        bit  lead;
        lead = 1'b1;
        if (run_len > 1) begin
            for (scale = 1000; scale >= 1; scale = scale / 10) begin
                dig = (run_len / scale) % 10;
                if (dig != 0 || !lead || scale == 1) begin
                    add_beat(ASCII_ZERO + t_sym'(dig), t_len'(1));
                    lead = 1'b0;
                end
            end
        end
        add_beat(run_sym, t_len'(1));
        run_len = 0;
    endfunction

    function automatic void predict_codec_beats(input t_sym s, input logic last);
        int acc;
        step_n = 0;
        if (codec_mode == MODE_COMPRESS) begin
            if (run_len == 0) begin
                run_sym = s;
                run_len = 1;
            end else if (s == run_sym) begin
                run_len++;
            end else begin
                close_run();
                run_sym = s;
                run_len = 1;
            end
            if (run_len >= RUN_LIMIT) begin
                close_run();
            end
            if (last && run_len != 0) begin
                close_run();
            end
        end else begin
            if (s >= ASCII_ZERO && s <= ASCII_NINE) begin
                acc = dec_count * 10 + int'(s - ASCII_ZERO);
                dec_count = (acc > RUN_LIMIT) ? RUN_LIMIT : acc;
            end else begin
                add_beat(s, (dec_count == 0) ? t_len'(1) : t_len'(dec_count));
                dec_count = 0;
            end
            if (last) begin
                dec_count = 0;
            end
        end
        if (last && step_n > 0) begin
            step_beats[step_n-1].eos = 1'b1;
        end
    endfunction

    task automatic send_symbol(input t_sym s, input logic last, input bit predicted);
        int k;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_codec_beats(s, last);
        if (predicted) begin
            for (k = 0; k < step_n; k++) codec_beats_due.push_back(step_beats[k]);
        end
        items_sent++;
    endtask

    // Stop offering input and let every expected beat drain before a mode write.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (codec_beats_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        codec_mode = m;
    endtask

    // Compress stimulus: a run of one byte, mostly from a small alphabet so that
    // neighboring runs sometimes merge.
    task automatic send_run();
        t_sym s;
        int   len;
        int   k;
        logic fin;
        if ($urandom_range(0, 3) != 0) begin
            s = t_sym'("a") + t_sym'($urandom_range(0, 2));
        end else begin
            s = t_sym'($urandom_range(0, 255));
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
            if (k == len - 1) begin
                fin = ($urandom_range(0, 5) == 0);
            end else begin
                fin = ($urandom_range(0, 29) == 0);
            end
            send_symbol(s, fin, 1'b1);
        end
    endtask

    // Decompress stimulus: mostly a count followed by a data byte, some bare
    // bytes and some counts cut off by the end of the stream.
    task automatic send_record();
        t_sym s;
        int   ndig;
        int   k;
        case ($urandom_range(0, 9))
            0: begin
                send_symbol(t_sym'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
            end
            1: begin
                ndig = $urandom_range(1, 3);
                for (k = 0; k < ndig; k++) begin
                    send_symbol(ASCII_ZERO + t_sym'($urandom_range(0, 9)), k == ndig - 1, 1'b1);
                end
            end
            default: begin
                ndig = $urandom_range(0, 4);
                for (k = 0; k < ndig; k++) begin
                    send_symbol(ASCII_ZERO + t_sym'($urandom_range(0, 9)), 1'b0, 1'b1);
                end
                do begin
                    s = t_sym'($urandom_range(0, 255));
                end while (s >= ASCII_ZERO && s <= ASCII_NINE);
                send_symbol(s, $urandom_range(0, 5) == 0, 1'b1);
            end
        endcase
    endtask

    // Output side: random back-pressure, plus a long hold-off on request.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_asked) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_beat = '{sym: o_m_tdata[SYM_W-1:0],
                         rep: o_m_tdata[SYM_W+LEN_W-1:SYM_W],
                         eos: o_m_tlast};
            if (codec_beats_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual sym %h rep %0d last %0b",
                         $time, got_beat.sym, got_beat.rep, got_beat.eos);
            end else begin
                want_beat = codec_beats_due.pop_front();
                if (got_beat.sym != want_beat.sym || got_beat.rep != want_beat.rep ||
                        got_beat.eos != want_beat.eos ||
                        o_m_tdata[M_TDATA_W-1:SYM_W+LEN_W] != '0) begin
                    errors++;
                    $display("%0t: mismatch, expected sym %h rep %0d last %0b pad 0,",
                             $time, want_beat.sym, want_beat.rep, want_beat.eos);
                    $display("%0t:           actual sym %h rep %0d last %0b pad %h",
                             $time, got_beat.sym, got_beat.rep, got_beat.eos,
                             o_m_tdata[M_TDATA_W-1:SYM_W+LEN_W]);
                end
            end
        end
    end

    initial begin
        row_t row;
        int   r;
        int   idle_sel;
        int   phase;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= MODE_COMPRESS;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        errors        = 0;
        items_sent    = 0;
        hold_asked    = 0;
        hold_served   = 0;
        hold_left     = 0;
        send_idle_pct = 28;
        recv_idle_pct = 68;
        codec_mode    = MODE_COMPRESS;
        run_sym       = '0;
        run_len       = 0;
        dec_count     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_COMPRESS);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.m != codec_mode) begin
                settle();
                write_mode(row.m);
            end
            for (r = 1; r <= int'(row.reps); r++) begin
                send_symbol(row.sym, row.last && r == int'(row.reps), !row.typed);
            end
            if (row.typed && row.n_exp) begin
                codec_beats_due.push_back('{sym: row.e_sym, rep: row.e_rep, eos: row.e_eos});
            end
        end

        for (idle_sel = 0; idle_sel < 3; idle_sel++) begin
            case (idle_sel)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Modes change mid-stream here, with open runs and counts carried over.
            for (phase = 0; phase < 3; phase++) begin
                settle();
                case (phase)
                    0: write_mode(MODE_COMPRESS);
                    1: write_mode(MODE_DECOMPRESS);
                    default: write_mode(t_mode'($urandom_range(0, 1)));
                endcase
                if (idle_sel == 2 && phase == 0) begin
                    hold_asked++;
                end
                items_sent = 0;
                while (items_sent < PHASE_ITEMS) begin
                    if (codec_mode == MODE_COMPRESS) begin
                        send_run();
                    end else begin
                        send_record();
                    end
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/rlcd_pkg.sv
src/run_length_codec_decimal_unit.sv
verif/tb_top.sv
